@@ src/double_ended_queue_macros.svh @@
// Assertion macros for the double-ended queue.
// Used by the top level; needs a clock named clock and a reset named reset.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// same-cycle implication
`define DEQ_ASSERT_IMPL(label, cond, conseq) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error("deque assertion failed");

// next-cycle implication
`define DEQ_ASSERT_NEXT(label, cond, conseq) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error("deque assertion failed");

`endif

@@ src/deq_pkg.sv @@
// Shared codes and command type for the double-ended queue.
// No dependencies; used by deq_ctrl, deq_datapath and the top level.
package deq_pkg;

   localparam logic [1:0] FUNC_PUSH_RIGHT = 2'd0;
   localparam logic [1:0] FUNC_PUSH_LEFT  = 2'd1;
   localparam logic [1:0] FUNC_POP_RIGHT  = 2'd2;
   localparam logic [1:0] FUNC_POP_LEFT   = 2'd3;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic load;   // capture the request word
      logic exec;   // update indices, access slot store
   } deq_cmd_type;

endpackage

@@ src/deq_ctrl.sv @@
// Controller for the double-ended queue: sequences load, execute, respond.
// Depends on deq_pkg for the command type.
module deq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output deq_pkg::deq_cmd_type cmd
);
   import deq_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign cmd.load  = req_valid && req_ready;
   assign cmd.exec  = (state_ff == ST_EXEC);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

@@ src/deq_datapath.sv @@
// Datapath for the double-ended queue: end indices, slot store, result word.
// Depends on deq_pkg for operation and status codes and the command type.
module deq_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  deq_pkg::deq_cmd_type cmd,
   input  logic [1:0]           req_func,
   input  logic signed [31:0]   req_push_value,
   output logic signed [31:0]   rsp_pop_value,
   output logic [1:0]           rsp_status
);
   import deq_pkg::*;

   // indices are kept offset by one so that -1 .. DEPTH-1 maps to 0 .. DEPTH
   localparam int IW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam logic [IW-1:0] CENTER = IW'(DEPTH / 2 + 1);
   localparam logic [IW-1:0] LIMIT  = IW'(DEPTH);
   localparam logic [IW-1:0] ONE    = IW'(1);

   logic [1:0]        func_ff;
   logic [31:0]       value_ff;
   logic [IW-1:0]     left_ff, left_in;
   logic [IW-1:0]     right_ff, right_in;
   logic [1:0]        status_ff, status_in;
   logic [31:0]       rd_ff;
   logic              wr_en;
   logic [IW-1:0]     slot_idx;
   logic              empty;

   logic [31:0] mem [DEPTH];

   assign empty = (left_ff == right_ff);

   always_comb begin
      left_in   = left_ff;
      right_in  = right_ff;
      status_in = STATUS_DONE;
      wr_en     = 1'b0;
      slot_idx  = right_ff;
      case (func_ff)
         FUNC_PUSH_RIGHT: begin
            slot_idx = right_ff;
            if (right_ff == LIMIT) begin
               status_in = STATUS_OVERFLOW;
            end else begin
               wr_en    = 1'b1;
               right_in = right_ff + ONE;
            end
         end
         FUNC_PUSH_LEFT: begin
            slot_idx = left_ff - ONE;
            if (left_ff == '0) begin
               status_in = STATUS_OVERFLOW;
            end else begin
               wr_en   = 1'b1;
               left_in = left_ff - ONE;
            end
         end
         FUNC_POP_RIGHT: begin
            slot_idx = right_ff - ONE;
            if (empty) status_in = STATUS_UNDERFLOW;
            else       right_in  = right_ff - ONE;
         end
         default: begin
            // pop left: slot just right of the left index
            slot_idx = left_ff;
            if (empty) status_in = STATUS_UNDERFLOW;
            else       left_in   = left_ff + ONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         value_ff <= req_push_value;
      end
      if (cmd.exec) begin
         status_ff <= status_in;
      end
   end

   // slot store; read data is masked unless a pop succeeded
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (wr_en) mem[AW'(slot_idx)] <= value_ff;
         rd_ff <= mem[AW'(slot_idx)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= CENTER;
         right_ff <= CENTER;
      end else if (cmd.exec) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign rsp_status    = status_ff;
   assign rsp_pop_value = (func_ff[1] && status_ff == STATUS_DONE) ? rd_ff : '0;

endmodule

@@ src/double_ended_queue.sv @@
// Top level of the double-ended queue: controller plus datapath.
// Depends on deq_pkg, deq_ctrl, deq_datapath and the assertion macro header.
//
//   channel | direction | handshake            | word
//   req     | in        | req_valid/req_ready  | req_func, req_push_value
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_pop_value, rsp_status
//
// Each word goes through accept, index update and slot store access
// (registered read), then the result word is offered.
// One word is in flight at a time; req_ready is low until the result is taken.
// A stalled rsp_ready holds the result and the block.
// Synchronous reset recenters both end indices; slot contents are not cleared.
`include "double_ended_queue_macros.svh"

module double_ended_queue #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic signed [31:0] req_push_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_pop_value,
   output logic [1:0]         rsp_status
);
   import deq_pkg::*;

   deq_cmd_type cmd;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   deq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_func       (req_func),
      .req_push_value (req_push_value),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status)
   );

   `DEQ_ASSERT_IMPL(a_no_overlap, rsp_valid, !req_ready)
   `DEQ_ASSERT_NEXT(a_accept_busy, req_valid && req_ready, !req_ready && !rsp_valid)
   `DEQ_ASSERT_IMPL(a_status_code, rsp_valid, rsp_status <= STATUS_UNDERFLOW)
   `DEQ_ASSERT_IMPL(a_fail_zero, rsp_valid && rsp_status != STATUS_DONE, rsp_pop_value == 32'sd0)

endmodule

@@ sim/tb_double_ended_queue.sv @@
`timescale 1ns / 100ps
// Testbench for double_ended_queue: directed end-limit and empty cases, then random push/pop
// traffic checked word by word against a behavioral deque. Depends on deq_pkg and the RTL.
module tb_double_ended_queue;
   import deq_pkg::*;

   localparam int DEPTH       = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 8;

   typedef struct packed {
      logic signed [31:0] pop_value;
      logic [1:0]         status;
   } deque_result_type;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_ready;
   logic [1:0]         req_func       = FUNC_PUSH_RIGHT;
   logic signed [31:0] req_push_value = '0;
   logic               rsp_valid;
   logic               rsp_ready      = 1'b0;
   logic signed [31:0] rsp_pop_value;
   logic [1:0]         rsp_status;

   double_ended_queue #(.DEPTH(DEPTH)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status)
   );

   // behavioral deque: live elements sit in left_end+1 .. right_end
   logic [31:0]      slot_store [DEPTH];
   int               left_end  = DEPTH / 2;
   int               right_end = DEPTH / 2;
   deque_result_type pending_results [$];

   int idle_chance     = 0;   // percent, both sides
   int stall_left      = 0;
   int cycle_count     = 0;
   int error_count     = 0;
   int push_count      = 0;
   int pop_count       = 0;
   int overflow_count  = 0;
   int underflow_count = 0;
   int checked_count   = 0;

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still due", cycle_count,
                  pending_results.size());
         $display("tb_double_ended_queue failed");
         $finish;
      end
   end

   function automatic deque_result_type deque_apply(input logic [1:0] func,
                                                    input logic [31:0] value);
      deque_result_type r;
      r.pop_value = '0;
      r.status    = STATUS_DONE;
      case (func)
         FUNC_PUSH_RIGHT: begin
            if (right_end >= DEPTH - 1) begin
               r.status = STATUS_OVERFLOW;
            end else begin
               right_end++;
               slot_store[right_end] = value;
            end
         end
         FUNC_PUSH_LEFT: begin
            if (left_end <= -1) begin
               r.status = STATUS_OVERFLOW;
            end else begin
               slot_store[left_end] = value;
               left_end--;
            end
         end
         FUNC_POP_RIGHT: begin
            if (right_end == left_end) begin
               r.status = STATUS_UNDERFLOW;
            end else begin
               r.pop_value = slot_store[right_end];
               right_end--;
            end
         end
         default: begin
            if (right_end == left_end) begin
               r.status = STATUS_UNDERFLOW;
            end else begin
               left_end++;
               r.pop_value = slot_store[left_end];
            end
         end
      endcase
      return r;
   endfunction

   function automatic logic [31:0] pick_value();
      logic [31:0] corners [5];
      corners = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1};
      if ($urandom_range(0, 7) == 0)
         return corners[$urandom_range(0, 4)];
      return $urandom;
   endfunction

   // Drives one word at the falling edge and waits for acceptance; the predictor
   // runs at the accepting edge. Valid stays high between back-to-back words.
   task automatic send_word(input logic [1:0] func, input logic [31:0] value);
      deque_result_type r;
      int               gap;
      if (idle_chance > 0 && $urandom_range(0, 99) < idle_chance) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_push_value <= value;
      do @(posedge clock); while (!req_ready);
      r = deque_apply(func, value);
      pending_results.push_back(r);
      if (r.status == STATUS_OVERFLOW)
         overflow_count++;
      else if (r.status == STATUS_UNDERFLOW)
         underflow_count++;
      else if (func == FUNC_PUSH_RIGHT || func == FUNC_PUSH_LEFT)
         push_count++;
      else
         pop_count++;
      @(negedge clock);
   endtask

   // receiver stalls in bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_chance > 0 && $urandom_range(0, 99) < idle_chance) begin
         stall_left <= $urandom_range(1, 10) - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      error_count++;
      if (error_count <= 10)
         $display("mismatch on %s at word %0d: expected %h, got %h", what,
                  checked_count, want, got);
   endtask

   always @(posedge clock) begin
      deque_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected word (pop_value)", '0, rsp_pop_value);
         end else begin
            want = pending_results.pop_front();
            if (rsp_pop_value !== want.pop_value)
               report_mismatch("pop_value", want.pop_value, rsp_pop_value);
            if (rsp_status !== want.status)
               report_mismatch("status", {30'b0, want.status}, {30'b0, rsp_status});
         end
         checked_count++;
      end
   end

   // both ends empty, corner values through each end, then empty again
   task automatic test_corner_values();
      send_word(FUNC_POP_RIGHT, 32'h0);
      send_word(FUNC_POP_LEFT, 32'hFFFF_FFFF);
      send_word(FUNC_PUSH_RIGHT, 32'h8000_0000);
      send_word(FUNC_PUSH_LEFT, 32'h7FFF_FFFF);
      send_word(FUNC_PUSH_RIGHT, 32'h0);
      send_word(FUNC_PUSH_LEFT, 32'hFFFF_FFFF);
      send_word(FUNC_POP_RIGHT, 32'h5555_5555);
      send_word(FUNC_POP_LEFT, 32'hAAAA_AAAA);
      send_word(FUNC_POP_RIGHT, 32'h0);
      send_word(FUNC_POP_LEFT, 32'h0);
      send_word(FUNC_POP_LEFT, 32'h0);
      send_word(FUNC_POP_RIGHT, 32'h0);
   endtask

   // fill to the right limit, refuse, drain from the left
   task automatic test_right_limit();
      while (right_end < DEPTH - 1)
         send_word(FUNC_PUSH_RIGHT, pick_value());
      send_word(FUNC_PUSH_RIGHT, pick_value());
      send_word(FUNC_PUSH_RIGHT, 32'hFFFF_FFFF);
      while (left_end != right_end)
         send_word(FUNC_POP_LEFT, pick_value());
      send_word(FUNC_POP_LEFT, 32'h0);
   endtask

   // fill to the left limit, refuse, drain from the right
   task automatic test_left_limit();
      while (left_end > -1)
         send_word(FUNC_PUSH_LEFT, pick_value());
      send_word(FUNC_PUSH_LEFT, pick_value());
      send_word(FUNC_PUSH_LEFT, 32'h0);
      while (left_end != right_end)
         send_word(FUNC_POP_RIGHT, pick_value());
      send_word(FUNC_POP_RIGHT, 32'h0);
   endtask

   // runs of fill, drain and mixed traffic; idling varies per run
   task automatic test_random_mix(input int n_words);
      int         sent;
      int         run_len;
      int         push_pct;
      logic [1:0] func;
      logic       is_push;
      sent = 0;
      while (sent < n_words) begin
         case ($urandom_range(0, 3))
            0:       push_pct = 80;
            1:       push_pct = 20;
            default: push_pct = 50;
         endcase
         case ($urandom_range(0, 2))
            0:       idle_chance = 0;
            1:       idle_chance = 10;
            default: idle_chance = 30;
         endcase
         run_len = $urandom_range(4, 20);
         repeat (run_len) begin
            is_push = ($urandom_range(0, 99) < push_pct);
            if (is_push)
               func = $urandom_range(0, 1) ? FUNC_PUSH_LEFT : FUNC_PUSH_RIGHT;
            else
               func = $urandom_range(0, 1) ? FUNC_POP_LEFT : FUNC_POP_RIGHT;
            send_word(func, pick_value());
            sent++;
         end
      end
   endtask

   // back to back, no idling on either side
   task automatic test_full_rate(input int n_words);
      idle_chance = 0;
      repeat (n_words)
         send_word(2'($urandom_range(0, 3)), pick_value());
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      idle_chance = 20;
      test_corner_values();
      test_right_limit();
      test_left_limit();
      test_random_mix(1400);
      test_full_rate(200);
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      $display("checked %0d words: %0d pushes, %0d pops, %0d overflows, %0d underflows",
               checked_count, push_count, pop_count, overflow_count, underflow_count);
      $display("%0d mismatches", error_count);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("tb_double_ended_queue passed");
      end else begin
         $display("tb_double_ended_queue failed");
      end
      $finish;
   end

endmodule
